[design/spatial_bin_accumulator_defines.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the spatial bin accumulator.
// ---------------------------------------------------------------------------
`ifndef SPATIAL_BIN_ACCUMULATOR_DEFINES_SVH
`define SPATIAL_BIN_ACCUMULATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SBA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SBA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/sba_pkg.sv]
// ---------------------------------------------------------------------------
// sba_pkg
// Shared widths, defaults, register indexes and types of the bin accumulator.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sba_pkg;

	// Field widths.
	localparam int POS_W       = 32;
	localparam int EXT_W       = 31;
	localparam int SUM_W       = 48;
	localparam int CNT_W       = 32;
	localparam int RBIN_W      = 12;
	localparam int MAX_CH      = 6;
	localparam int BIN_FIELD_W = 16;
	localparam int DEPTH_W     = 17;
	localparam int CFG_IDX_W   = 4;
	localparam int CFG_DATA_W  = 32;
	localparam int QUEUE_DEPTH = 4;

	// Parameter defaults.
	localparam int DEF_DEPTH    = 4096;
	localparam int DEF_CHANNELS = 6;
	localparam int DEF_FRAC     = 16;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X   = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y   = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z   = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_EXTENT_X   = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_EXTENT_Y   = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_EXTENT_Z   = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_PROJECT    = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_AVERAGE_ON = 4'd7;

	typedef logic [POS_W-1:0] word_t;
	typedef logic [SUM_W-1:0] sum_t;

	// Geometry and readout configuration.
	typedef struct packed {
		word_t [2:0]            origin;
		logic [2:0][EXT_W-1:0]  extent;
		logic [2:0]             project_mask;
		logic                   average_on;
	} cfg_t;

	// One classified transaction waiting for the back end.
	typedef struct packed {
		logic                     mode;
		logic                     in_store;
		logic [BIN_FIELD_W-1:0]   bin;
		logic [RBIN_W-1:0]        rbin;
		word_t [MAX_CH-1:0]       stress;
	} qent_t;

endpackage

`default_nettype wire

[design/sba_ram.sv]
// ---------------------------------------------------------------------------
// sba_ram
// Generic single-write, single-read RAM with a registered read port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sba_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

[design/sba_queue.sv]
// ---------------------------------------------------------------------------
// sba_queue
// Short queue of classified transactions between the front and back ends.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sba_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  sba_pkg::qent_t wdata,
	input  logic          pop,
	output sba_pkg::qent_t head,
	output logic          full,
	output logic          empty
);
	import sba_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	qent_t            mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;

	assign full  = (count_q == (PTR_W + 1)'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

`default_nettype wire

[design/sba_front.sv]
// ---------------------------------------------------------------------------
// sba_front
// Accepts transactions, computes the linear bin of a particle and filters it.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sba_front #(
	parameter int BIN_STORE_DEPTH = sba_pkg::DEF_DEPTH,
	parameter int FRAC_BITS       = sba_pkg::DEF_FRAC
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  sba_pkg::cfg_t                       cfg,
	input  logic                                hold,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                mode,
	input  sba_pkg::word_t                      pos_x,
	input  sba_pkg::word_t                      pos_y,
	input  sba_pkg::word_t                      pos_z,
	input  sba_pkg::word_t [sba_pkg::MAX_CH-1:0] stress,
	input  logic [sba_pkg::RBIN_W-1:0]          read_bin,
	output logic                                q_push,
	output sba_pkg::qent_t                      q_data,
	input  logic                                q_full
);
	import sba_pkg::*;

	localparam int AW     = (BIN_STORE_DEPTH > 1) ? $clog2(BIN_STORE_DEPTH) : 1;
	localparam int IDX_W  = POS_W - FRAC_BITS;
	localparam int NB_W   = EXT_W - FRAC_BITS;
	localparam int P1_W   = 2 * NB_W;
	localparam int T_W    = P1_W + 1;
	localparam int P2_W   = NB_W + AW;
	localparam int B_W    = P2_W + 1;
	localparam int CMP1_W = (T_W > DEPTH_W) ? T_W : DEPTH_W;
	localparam int CMP2_W = (B_W > DEPTH_W) ? B_W : DEPTH_W;

	logic              advance;
	word_t [2:0]       pos_a;
	logic [2:0]        ok_c;
	logic [NB_W-1:0]   idx_c [3];
	logic [NB_W-1:0]   nb_c [3];
	qent_t             ent_c;

	logic              v_s1, v_s2, v_s3, v_s4;
	qent_t             ent_s1, ent_s2, ent_s3, ent_s4;
	logic              ok_s1, ok_s2, ok_s3, ok_s4;
	logic [NB_W-1:0]   idx_s1 [3];
	logic [NB_W-1:0]   nb_s1 [3];
	logic [NB_W-1:0]   idx_x_s2, nb_x_s2, idx_y_s2;
	logic [P1_W-1:0]   p1_s2;
	logic [NB_W-1:0]   idx_x_s3, nb_x_s3;
	logic [AW-1:0]     t_s3;
	logic [NB_W-1:0]   idx_x_s4;
	logic [P2_W-1:0]   p2_s4;

	logic [P1_W-1:0]   p1;
	logic [T_W-1:0]    t_sum;
	logic              t_ok;
	logic [P2_W-1:0]   p2;
	logic [B_W-1:0]    b_sum;
	logic              b_ok;

	// The whole pipeline moves together unless the last stage is blocked.
	assign advance  = !(v_s4 && q_full);
	assign in_stall = !advance || hold;

	assign pos_a = {pos_z, pos_y, pos_x};

	// Per-axis offset, range check and bin index.
	for (genvar a = 0; a < 3; a++) begin : g_axis
		logic [POS_W:0]    d;
		logic [IDX_W-1:0]  idx_full;
		logic [NB_W-1:0]   nb_full;

		assign d = {pos_a[a][POS_W-1], pos_a[a]} -
			{cfg.origin[a][POS_W-1], cfg.origin[a]};
		assign idx_full = d[POS_W-1:FRAC_BITS];
		assign nb_full  = cfg.extent[a][EXT_W-1:FRAC_BITS];

		always_comb begin
			if (cfg.project_mask[a]) begin
				ok_c[a]  = !d[POS_W] && (d[POS_W-1:0] < {1'b0, cfg.extent[a]});
				idx_c[a] = '0;
				nb_c[a]  = NB_W'(1);
			end else begin
				ok_c[a]  = !d[POS_W] && (idx_full < IDX_W'(nb_full));
				idx_c[a] = NB_W'(idx_full);
				nb_c[a]  = nb_full;
			end
		end
	end

	// Payload carried along with the bin computation.
	always_comb begin
		ent_c          = '0;
		ent_c.mode     = mode;
		ent_c.in_store = (DEPTH_W'(read_bin) < DEPTH_W'(BIN_STORE_DEPTH));
		ent_c.rbin     = read_bin;
		ent_c.stress   = stress;
	end

	// Linear id: t = iy + ny*iz, then bin = ix + nx*t.
	assign p1    = P1_W'(nb_s1[1]) * P1_W'(idx_s1[2]);
	assign t_sum = T_W'(idx_y_s2) + T_W'(p1_s2);
	assign t_ok  = (CMP1_W'(t_sum) < CMP1_W'(BIN_STORE_DEPTH));
	assign p2    = P2_W'(nb_x_s3) * P2_W'(t_s3);
	assign b_sum = B_W'(idx_x_s4) + B_W'(p2_s4);
	assign b_ok  = (CMP2_W'(b_sum) < CMP2_W'(BIN_STORE_DEPTH));

	// Readouts always go on; particles only when they land inside the store.
	always_comb begin
		q_data = ent_s4;
		if (ent_s4.mode) begin
			q_data.bin = BIN_FIELD_W'(ent_s4.rbin);
		end else begin
			q_data.bin = BIN_FIELD_W'(b_sum[AW-1:0]);
		end
		q_push = v_s4 && !q_full && (ent_s4.mode || (ok_s4 && b_ok));
	end

	// Stage valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (advance) begin
			v_s1 <= in_valid && !hold;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// Stage payloads.
	always_ff @(posedge clk) begin
		if (advance) begin
			ent_s1   <= ent_c;
			ok_s1    <= &ok_c;
			for (int a = 0; a < 3; a++) begin
				idx_s1[a] <= idx_c[a];
				nb_s1[a]  <= nb_c[a];
			end
			ent_s2   <= ent_s1;
			ok_s2    <= ok_s1;
			idx_x_s2 <= idx_s1[0];
			nb_x_s2  <= nb_s1[0];
			idx_y_s2 <= idx_s1[1];
			p1_s2    <= p1;
			ent_s3   <= ent_s2;
			ok_s3    <= ok_s2 && t_ok;
			idx_x_s3 <= idx_x_s2;
			nb_x_s3  <= nb_x_s2;
			t_s3     <= AW'(t_sum);
			ent_s4   <= ent_s3;
			ok_s4    <= ok_s3;
			idx_x_s4 <= idx_x_s3;
			p2_s4    <= p2;
		end
	end

endmodule

`default_nettype wire

[design/sba_back.sv]
// ---------------------------------------------------------------------------
// sba_back
// Clears the bin store, applies particles to it and serves bin readouts.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "spatial_bin_accumulator_defines.svh"

module sba_back #(
	parameter int BIN_STORE_DEPTH = sba_pkg::DEF_DEPTH,
	parameter int CHANNELS        = sba_pkg::DEF_CHANNELS
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 average_on,
	input  logic                                 q_empty,
	input  sba_pkg::qent_t                       q_head,
	output logic                                 q_pop,
	output logic                                 clearing,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [sba_pkg::RBIN_W-1:0]           bin_number,
	output logic [sba_pkg::CNT_W-1:0]            particle_count,
	output sba_pkg::sum_t [sba_pkg::MAX_CH-1:0]  chan
);
	import sba_pkg::*;

	localparam int AW     = (BIN_STORE_DEPTH > 1) ? $clog2(BIN_STORE_DEPTH) : 1;
	localparam int ROW_W  = CHANNELS * SUM_W;
	localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int STEP_W = $clog2(SUM_W);
	localparam int EXT_S  = SUM_W + 1 - POS_W;

	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(SUM_W - 1);
	localparam logic [CH_W-1:0]   CH_LAST   = CH_W'(CHANNELS - 1);
	localparam logic [AW-1:0]     ADDR_LAST = AW'(BIN_STORE_DEPTH - 1);
	localparam logic [SUM_W-1:0]  SUM_MAX   = {1'b0, {(SUM_W - 1){1'b1}}};
	localparam logic [SUM_W-1:0]  SUM_MIN   = {1'b1, {(SUM_W - 1){1'b0}}};

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_DATA  = 3'd2;
	localparam logic [2:0] ST_DIV   = 3'd3;
	localparam logic [2:0] ST_OUT   = 3'd4;

	function automatic logic [SUM_W-1:0] mag_of(input logic [SUM_W-1:0] v);
		return v[SUM_W-1] ? -v : v;
	endfunction

	logic [2:0]        state_q, state_d;
	logic [AW-1:0]     clr_addr_q;
	logic              out_valid_q;
	qent_t             entry_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [RBIN_W-1:0] bin_q;
	logic [SUM_W-1:0]  sums_q [CHANNELS];
	logic [CH_W-1:0]   ch_q;
	logic [STEP_W-1:0] step_q;
	logic [SUM_W-1:0]  mag_q;
	logic [CNT_W:0]    rem_q;
	logic              neg_q;

	logic              ram_we, ram_re;
	logic [AW-1:0]     ram_waddr, ram_raddr;
	logic [CNT_W-1:0]  cnt_wdata, cnt_rdata;
	logic [ROW_W-1:0]  sum_wdata, sum_rdata, sum_acc;
	logic              load_ok;

	logic [CNT_W:0]    rem_sh, rem_nx;
	logic              ge;
	logic [SUM_W-1:0]  quo_nx, quo_signed, next_head;

	// Bin counts and channel sums, one row per bin.
	sba_ram #(.WIDTH(CNT_W), .DEPTH(BIN_STORE_DEPTH)) u_cnt_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (cnt_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (cnt_rdata)
	);

	sba_ram #(.WIDTH(ROW_W), .DEPTH(BIN_STORE_DEPTH)) u_sum_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (sum_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (sum_rdata)
	);

	// Saturating add of each stress value to its channel sum.
	for (genvar c = 0; c < CHANNELS; c++) begin : g_acc
		logic [SUM_W:0] s;
		logic [SUM_W-1:0] old;

		assign old = sum_rdata[c*SUM_W +: SUM_W];
		assign s = {old[SUM_W-1], old} +
			{{EXT_S{entry_q.stress[c][POS_W-1]}}, entry_q.stress[c]};
		assign sum_acc[c*SUM_W +: SUM_W] = (s[SUM_W] != s[SUM_W-1]) ?
			(s[SUM_W] ? SUM_MIN : SUM_MAX) : s[SUM_W-1:0];
	end

	// Restoring divider step: one quotient bit per cycle.
	assign rem_sh     = {rem_q[CNT_W-1:0], mag_q[SUM_W-1]};
	assign ge         = (rem_sh >= {1'b0, cnt_q});
	assign rem_nx     = ge ? (rem_sh - {1'b0, cnt_q}) : rem_sh;
	assign quo_nx     = {mag_q[SUM_W-2:0], ge};
	assign quo_signed = neg_q ? -quo_nx : quo_nx;

	if (CHANNELS > 1) begin : g_next
		assign next_head = sums_q[1];
	end else begin : g_next_one
		assign next_head = quo_signed;
	end

	// Readouts of empty bins while averaging, or outside the store, give zeros.
	assign load_ok = entry_q.in_store && !(average_on && (cnt_rdata == '0));

	// Sequencer and memory control.
	always_comb begin
		state_d   = state_q;
		q_pop     = 1'b0;
		ram_re    = 1'b0;
		ram_raddr = q_head.bin[AW-1:0];
		ram_we    = 1'b0;
		ram_waddr = entry_q.bin[AW-1:0];
		cnt_wdata = (cnt_rdata == '1) ? cnt_rdata : (cnt_rdata + 1'b1);
		sum_wdata = sum_acc;
		unique case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_addr_q;
				cnt_wdata = '0;
				sum_wdata = '0;
				if (clr_addr_q == ADDR_LAST) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (!q_empty) begin
					q_pop   = 1'b1;
					ram_re  = 1'b1;
					state_d = ST_DATA;
				end
			end
			ST_DATA: begin
				if (!entry_q.mode) begin
					ram_we  = 1'b1;
					state_d = ST_IDLE;
				end else if (average_on && entry_q.in_store && (cnt_rdata != '0)) begin
					state_d = ST_DIV;
				end else begin
					state_d = ST_OUT;
				end
			end
			ST_DIV: begin
				if ((step_q == STEP_LAST) && (ch_q == CH_LAST)) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (!out_stall) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_addr_q  <= '0;
			out_valid_q <= 1'b0;
			ch_q        <= '0;
			step_q      <= '0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= (state_d == ST_OUT);
			if (state_q == ST_CLEAR) begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
			if (state_q == ST_DATA) begin
				ch_q   <= '0;
				step_q <= '0;
			end else if (state_q == ST_DIV) begin
				if (step_q == STEP_LAST) begin
					step_q <= '0;
					ch_q   <= ch_q + 1'b1;
				end else begin
					step_q <= step_q + 1'b1;
				end
			end
		end
	end

	// Readout data and divider datapath.
	always_ff @(posedge clk) begin
		if (q_pop) begin
			entry_q <= q_head;
		end
		case (state_q)
			ST_DATA: begin
				if (entry_q.mode) begin
					bin_q <= entry_q.rbin;
					cnt_q <= entry_q.in_store ? cnt_rdata : '0;
					for (int i = 0; i < CHANNELS; i++) begin
						sums_q[i] <= load_ok ? sum_rdata[i*SUM_W +: SUM_W] : '0;
					end
					neg_q <= sum_rdata[SUM_W-1];
					mag_q <= mag_of(sum_rdata[SUM_W-1:0]);
					rem_q <= '0;
				end
			end
			ST_DIV: begin
				if (step_q == STEP_LAST) begin
					// Rotate the channels so the next one sits at the head.
					for (int i = 0; i < CHANNELS - 1; i++) begin
						sums_q[i] <= sums_q[i+1];
					end
					sums_q[CHANNELS-1] <= quo_signed;
					neg_q <= next_head[SUM_W-1];
					mag_q <= mag_of(next_head);
					rem_q <= '0;
				end else begin
					mag_q <= quo_nx;
					rem_q <= rem_nx;
				end
			end
			default: begin
			end
		endcase
	end

	assign clearing       = (state_q == ST_CLEAR);
	assign out_valid      = out_valid_q;
	assign bin_number     = bin_q;
	assign particle_count = cnt_q;

	for (genvar k = 0; k < MAX_CH; k++) begin : g_chan
		if (k < CHANNELS) begin : g_used
			assign chan[k] = sums_q[k];
		end else begin : g_unused
			assign chan[k] = '0;
		end
	end

	`SBA_ASSERT_IMPL(a_clear_quiet, clk, arst_n, state_q == ST_CLEAR, !q_pop && !out_valid_q, "store touched during clearing")
	`SBA_ASSERT_IMPL(a_out_state, clk, arst_n, out_valid_q, state_q == ST_OUT, "result shown outside output state")
	`SBA_ASSERT_IMPL(a_div_nonzero, clk, arst_n, state_q == ST_DIV, cnt_q != '0, "division by an empty bin count")
	`SBA_ASSERT_NEXT(a_out_release, clk, arst_n, out_valid_q && !out_stall, !out_valid_q, "result delivered twice")

endmodule

`default_nettype wire

[design/spatial_bin_accumulator.sv]
// ---------------------------------------------------------------------------
// spatial_bin_accumulator
// 3-D particle binning with saturating per-bin counts and channel sums.
// ---------------------------------------------------------------------------
// After reset the block clears its bin store, one bin per cycle, over all
// BIN_STORE_DEPTH bins (4096 by default); input stays stalled meanwhile but
// configuration writes are taken. A four-stage front end computes the bin of
// each transaction and hands it through a four-entry queue to the back end,
// which owns the bin memories. A particle takes the back end through a read,
// then a write of the bin row, and the next one is taken only after that
// write. A readout reads the bin row, loads it and, with averaging on and a
// non-empty bin, runs the shared bit-serial divider over each channel; the
// result is held in the output register until taken. The front end keeps
// accepting while the queue has room.
`timescale 1ns / 1ps
`default_nettype none

module spatial_bin_accumulator #(
	parameter int BIN_STORE_DEPTH = sba_pkg::DEF_DEPTH,
	parameter int CHANNELS        = sba_pkg::DEF_CHANNELS,
	parameter int FRAC_BITS       = sba_pkg::DEF_FRAC
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// Configuration write channel.
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [sba_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [sba_pkg::CFG_DATA_W-1:0]      cfg_data,
	// Input channel.
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                mode,
	input  logic signed [31:0]                  pos_x,
	input  logic signed [31:0]                  pos_y,
	input  logic signed [31:0]                  pos_z,
	input  logic signed [31:0]                  stress_0,
	input  logic signed [31:0]                  stress_1,
	input  logic signed [31:0]                  stress_2,
	input  logic signed [31:0]                  stress_3,
	input  logic signed [31:0]                  stress_4,
	input  logic signed [31:0]                  stress_5,
	input  logic [11:0]                         read_bin,
	// Output channel.
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [11:0]                         bin_number,
	output logic [31:0]                         particle_count,
	output logic signed [47:0]                  chan_0,
	output logic signed [47:0]                  chan_1,
	output logic signed [47:0]                  chan_2,
	output logic signed [47:0]                  chan_3,
	output logic signed [47:0]                  chan_4,
	output logic signed [47:0]                  chan_5
);
	import sba_pkg::*;

	cfg_t                 cfg_q;
	word_t [MAX_CH-1:0]   stress_a;
	sum_t [MAX_CH-1:0]    chan_a;
	logic                 q_push, q_pop, q_full, q_empty, clearing;
	qent_t                q_wdata, q_head;

	// Configuration registers; writes are always taken.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.origin       <= '0;
			cfg_q.extent[0]    <= EXT_W'(65536);
			cfg_q.extent[1]    <= EXT_W'(65536);
			cfg_q.extent[2]    <= EXT_W'(65536);
			cfg_q.project_mask <= 3'b111;
			cfg_q.average_on   <= 1'b1;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_ORIGIN_X:   cfg_q.origin[0]    <= cfg_data;
				REG_ORIGIN_Y:   cfg_q.origin[1]    <= cfg_data;
				REG_ORIGIN_Z:   cfg_q.origin[2]    <= cfg_data;
				REG_EXTENT_X:   cfg_q.extent[0]    <= cfg_data[EXT_W-1:0];
				REG_EXTENT_Y:   cfg_q.extent[1]    <= cfg_data[EXT_W-1:0];
				REG_EXTENT_Z:   cfg_q.extent[2]    <= cfg_data[EXT_W-1:0];
				REG_PROJECT:    cfg_q.project_mask <= cfg_data[2:0];
				REG_AVERAGE_ON: cfg_q.average_on   <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	assign stress_a = {stress_5, stress_4, stress_3, stress_2, stress_1, stress_0};

	// Front end: accept and classify.
	sba_front #(
		.BIN_STORE_DEPTH (BIN_STORE_DEPTH),
		.FRAC_BITS       (FRAC_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.hold     (clearing),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.mode     (mode),
		.pos_x    (pos_x),
		.pos_y    (pos_y),
		.pos_z    (pos_z),
		.stress   (stress_a),
		.read_bin (read_bin),
		.q_push   (q_push),
		.q_data   (q_wdata),
		.q_full   (q_full)
	);

	// Queue between the two ends.
	sba_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.head   (q_head),
		.full   (q_full),
		.empty  (q_empty)
	);

	// Back end: bin store update and readout.
	sba_back #(
		.BIN_STORE_DEPTH (BIN_STORE_DEPTH),
		.CHANNELS        (CHANNELS)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.average_on     (cfg_q.average_on),
		.q_empty        (q_empty),
		.q_head         (q_head),
		.q_pop          (q_pop),
		.clearing       (clearing),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.bin_number     (bin_number),
		.particle_count (particle_count),
		.chan           (chan_a)
	);

	assign chan_0 = chan_a[0];
	assign chan_1 = chan_a[1];
	assign chan_2 = chan_a[2];
	assign chan_3 = chan_a[3];
	assign chan_4 = chan_a[4];
	assign chan_5 = chan_a[5];

endmodule

`default_nettype wire
